FILE: rtl/alse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alse_pkg
// Shared types and constants of the array list shift engine: operation and
// status codes, the sequencer states and the commands broadcast to the cells.
// ----------------------------------------------------------------------------
package alse_pkg;

  // Default list geometry.
  localparam int DEPTH_DEF      = 64;
  localparam int ITEM_WIDTH_DEF = 16;

  // Fixed field widths of the request and result channels.
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;

  // Operation codes carried by a request.
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_DUMP      = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE,
    S_DUMP
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SEARCH,
    CELL_ROTATE
  } cell_op_t;

endpackage
`default_nettype wire

FILE: rtl/alse_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alse_in_if
// Request channel: one list operation per request.
// ----------------------------------------------------------------------------
interface alse_in_if #(
  parameter int ITEM_WIDTH = alse_pkg::ITEM_WIDTH_DEF
);
  import alse_pkg::*;

  logic                  valid;
  logic                  ready;
  op_t                   op;
  logic [POS_W-1:0]      position;
  logic [ITEM_WIDTH-1:0] item;

  modport source (output valid, output op, output position, output item, input ready);
  modport sink   (input valid, input op, input position, input item, output ready);

endinterface
`default_nettype wire

FILE: rtl/alse_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alse_out_if
// Result channel: one or more results per request.
// ----------------------------------------------------------------------------
interface alse_out_if #(
  parameter int ITEM_WIDTH = alse_pkg::ITEM_WIDTH_DEF
);
  import alse_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ITEM_WIDTH-1:0] item_out;
  status_t               status;
  logic                  found;
  logic [COUNT_W-1:0]    count;
  logic                  last;

  modport source (output valid, output item_out, output status, output found,
                  output count, output last, input ready);
  modport sink   (input valid, input item_out, input status, input found,
                  input count, input last, output ready);

endinterface
`default_nettype wire

FILE: rtl/alse_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alse_cell
// One list slot. Holds an entry and moves it to or from its neighbors under
// the broadcast command; also probes its entry for search and remove.
// ----------------------------------------------------------------------------
module alse_cell #(
  parameter int ITEM_WIDTH = 16,
  parameter int IDX_W      = 7,
  parameter int IDX        = 0
) (
  input  wire                   clk,
  input  alse_pkg::cell_op_t    op,
  input  wire [IDX_W-1:0]       sel,
  input  wire [IDX_W-1:0]       cnt,
  input  wire [ITEM_WIDTH-1:0]  item,
  input  wire [ITEM_WIDTH-1:0]  left_in,
  input  wire [ITEM_WIDTH-1:0]  right_in,
  input  wire [ITEM_WIDTH-1:0]  head_in,
  output logic [ITEM_WIDTH-1:0] data_out,
  output logic [ITEM_WIDTH-1:0] tap_out,
  output logic                  match_out
);
  import alse_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [ITEM_WIDTH-1:0] data_r, data_nxt;
  logic [ITEM_WIDTH-1:0] tap_r, tap_nxt;
  logic                  match_r, match_nxt;

  // Slot update and probe results for the current command.
  always_comb begin
    data_nxt  = data_r;
    tap_nxt   = tap_r;
    match_nxt = match_r;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_CLEAR: begin
        tap_nxt   = '0;
        match_nxt = 1'b0;
      end
      CELL_INSERT: begin
        // Slots above the insert point take their lower neighbor.
        if (MY_IDX > sel) begin
          data_nxt = left_in;
        end else if (MY_IDX == sel) begin
          data_nxt = item;
        end
        tap_nxt   = '0;
        match_nxt = 1'b0;
      end
      CELL_REMOVE: begin
        // The removed slot reports its entry; it and all above take the upper neighbor.
        if (MY_IDX >= sel) begin
          data_nxt = right_in;
        end
        tap_nxt   = (MY_IDX == sel) ? data_r : '0;
        match_nxt = 1'b0;
      end
      CELL_SEARCH: begin
        tap_nxt   = '0;
        match_nxt = (MY_IDX < cnt) && (data_r == item);
      end
      CELL_ROTATE: begin
        // The used part of the chain turns by one; the head wraps to the tail.
        if (MY_IDX < sel) begin
          data_nxt = right_in;
        end else if (MY_IDX == sel) begin
          data_nxt = head_in;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    tap_r   <= tap_nxt;
    match_r <= match_nxt;
  end

  assign data_out  = data_r;
  assign tap_out   = tap_r;
  assign match_out = match_r;

endmodule
`default_nettype wire

FILE: rtl/alse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alse_ctrl
// Sequencer of the list: checks each request against the fill count, issues
// the command to the cell chain, and drives the registered result channel.
// ----------------------------------------------------------------------------
module alse_ctrl #(
  parameter int DEPTH      = alse_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = alse_pkg::ITEM_WIDTH_DEF,
  parameter int IDX_W      = 7
) (
  input  wire                   clk,
  input  wire                   rst_n,
  alse_in_if.sink               in_ch,
  alse_out_if.source            out_ch,
  input  wire [ITEM_WIDTH-1:0]  head,
  input  wire [ITEM_WIDTH-1:0]  tap_or,
  input  wire                   hit,
  output alse_pkg::cell_op_t    cell_op,
  output logic [IDX_W-1:0]      sel_idx,
  output logic [IDX_W-1:0]      cnt_idx
);
  import alse_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      didx_r, didx_nxt;
  status_t               st_r, st_nxt;
  logic                  ov_r, ov_nxt;
  logic [ITEM_WIDTH-1:0] oitem_r, oitem_nxt;
  status_t               ost_r, ost_nxt;
  logic                  ofound_r, ofound_nxt;
  logic [CNT_W-1:0]      ocnt_r, ocnt_nxt;
  logic                  olast_r, olast_nxt;

  logic             out_free;
  logic [IDX_W-1:0] pos_ext;
  logic [IDX_W-1:0] cnt_ext;
  logic             is_full;
  logic             is_empty;
  logic             dump_last;

  assign out_free  = !ov_r || out_ch.ready;
  assign pos_ext   = IDX_W'(in_ch.position);
  assign cnt_ext   = IDX_W'(count_r);
  assign is_full   = (count_r == FULL_CNT);
  assign is_empty  = (count_r == '0);
  assign dump_last = (didx_r == count_r - ONE);
  assign cnt_idx   = cnt_ext;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, cell commands and result loading.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    didx_nxt    = didx_r;
    st_nxt      = st_r;
    ov_nxt      = ov_r && !out_ch.ready;
    oitem_nxt   = oitem_r;
    ost_nxt     = ost_r;
    ofound_nxt  = ofound_r;
    ocnt_nxt    = ocnt_r;
    olast_nxt   = olast_r;
    cell_op     = CELL_HOLD;
    sel_idx     = '0;
    in_ch.ready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = S_RESOLVE;
          unique case (in_ch.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              priority case (in_ch.op)
                OP_INS_FRONT: sel_idx = '0;
                OP_INS_BACK:  sel_idx = cnt_ext;
                default:      sel_idx = pos_ext;
              endcase
              // A full list is reported before a bad position.
              priority if (is_full) begin
                st_nxt = ST_FULL;
              end else if (sel_idx > cnt_ext) begin
                st_nxt = ST_RANGE;
              end else begin
                st_nxt = ST_OK;
              end
              if (st_nxt == ST_OK) begin
                cell_op   = CELL_INSERT;
                count_nxt = count_r + ONE;
              end else begin
                cell_op = CELL_CLEAR;
              end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
              priority case (in_ch.op)
                OP_REM_FRONT: sel_idx = '0;
                OP_REM_BACK:  sel_idx = is_empty ? '0 : cnt_ext - IDX_ONE;
                default:      sel_idx = pos_ext;
              endcase
              // An empty list is reported before a bad position.
              priority if (is_empty) begin
                st_nxt = ST_EMPTY;
              end else if (sel_idx >= cnt_ext) begin
                st_nxt = ST_RANGE;
              end else begin
                st_nxt = ST_OK;
              end
              if (st_nxt == ST_OK) begin
                cell_op   = CELL_REMOVE;
                count_nxt = count_r - ONE;
              end else begin
                cell_op = CELL_CLEAR;
              end
            end
            OP_SEARCH: begin
              st_nxt  = ST_OK;
              cell_op = CELL_SEARCH;
            end
            OP_DUMP: begin
              st_nxt = ST_OK;
              if (is_empty) begin
                // An empty dump gives a single result with a zero item.
                cell_op = CELL_CLEAR;
              end else begin
                state_nxt = S_DUMP;
                didx_nxt  = '0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          oitem_nxt  = tap_or;
          ost_nxt    = st_r;
          ofound_nxt = hit;
          ocnt_nxt   = count_r;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DUMP: begin
        // Emit the head and turn the chain, so the list is restored at the end.
        sel_idx = cnt_ext - IDX_ONE;
        if (out_free) begin
          ov_nxt     = 1'b1;
          oitem_nxt  = head;
          ost_nxt    = ST_OK;
          ofound_nxt = 1'b0;
          ocnt_nxt   = count_r;
          olast_nxt  = dump_last;
          cell_op    = CELL_ROTATE;
          didx_nxt   = didx_r + ONE;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      count_r <= '0;
    end else begin
      ov_r    <= ov_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    didx_r   <= didx_nxt;
    st_r     <= st_nxt;
    oitem_r  <= oitem_nxt;
    ost_r    <= ost_nxt;
    ofound_r <= ofound_nxt;
    ocnt_r   <= ocnt_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.item_out = oitem_r;
  assign out_ch.status   = ost_r;
  assign out_ch.found    = ofound_r;
  assign out_ch.count    = COUNT_W'(ocnt_r);
  assign out_ch.last     = olast_r;

  // The fill count never passes the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  // A non-dump request always goes on to produce its single result.
  a_req_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op != OP_DUMP) |=> state_r == S_RESOLVE)
    else $error("request did not move to resolve");

  // A dump walks only the filled part of the chain.
  a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> didx_r < count_r)
    else $error("dump index beyond fill count");

  // A dump leaves the fill count unchanged.
  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |=> $stable(count_r))
    else $error("fill count moved during dump");

  // A failed operation leaves the fill count unchanged.
  a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && st_r != ST_OK) |-> $stable(count_r))
    else $error("failed operation changed fill count");

endmodule
`default_nettype wire

FILE: rtl/array_list_shift_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Requests are taken only in the idle state, so intake pauses during a dump. The resolve
// state loads each non-dump result into the output register once free, then goes to idle.
// Dump of N entries gives N results, one per cycle while the result side keeps up,
// as the cell chain rotates by one slot. A dump of an empty list gives one result.
// Reset (synchronous, active low) clears the fill count and the result valid; the entry
// cells are not cleared, there is no clearing pass.
// ----------------------------------------------------------------------------
// array_list_shift_engine_top
// Bounded ordered list of handles held in a chain of shifting cells, with a
// sequencer for insert, remove, search and dump requests.
// ----------------------------------------------------------------------------
module array_list_shift_engine_top #(
  parameter int DEPTH      = alse_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = alse_pkg::ITEM_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  alse_in_if.sink     in_ch,
  alse_out_if.source  out_ch
);
  import alse_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  cell_op_t              cell_op;
  logic [IDX_W-1:0]      sel_idx;
  logic [IDX_W-1:0]      cnt_idx;
  logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [ITEM_WIDTH-1:0] tap_or;
  logic                  hit;

  // Sequencer and result register.
  alse_ctrl #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .head    (cell_data[0]),
    .tap_or  (tap_or),
    .hit     (hit),
    .cell_op (cell_op),
    .sel_idx (sel_idx),
    .cnt_idx (cnt_idx)
  );

  // Chain of cells; the ends see zero beyond the chain.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_w;
    logic [ITEM_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[i+1];
    end

    alse_cell #(
      .ITEM_WIDTH (ITEM_WIDTH),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .sel       (sel_idx),
      .cnt       (cnt_idx),
      .item      (in_ch.item),
      .left_in   (left_w),
      .right_in  (right_w),
      .head_in   (cell_data[0]),
      .data_out  (cell_data[i]),
      .tap_out   (cell_tap[i]),
      .match_out (cell_match[i])
    );
  end

  // Merge the registered probes: at most one cell taps a removed entry.
  always_comb begin
    tap_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tap_or = tap_or | cell_tap[k];
    end
  end

  assign hit = |cell_match;

endmodule
`default_nettype wire

FILE: dv/alse_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_result_check
// Watches the request and result channels of the array list shift engine.
// Keeps its own copy of the list, works out the results that each accepted
// request must give, and compares every accepted result with the oldest one
// still awaited. It hands the failure count, the number of results still
// awaited and the current list size to the testbench top.
// ----------------------------------------------------------------------------
module alse_result_check (
  input  wire  clk,
  input  wire  rst_n,
  alse_in_if   in_mon,
  alse_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   list_size
);
  import alse_pkg::*;

  localparam int IW = ITEM_WIDTH_DEF;

  // One result as the block should present it.
  typedef struct {
    logic [IW-1:0]      item_out;
    status_t            status;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               last;
  } list_result_t;

  // List contents, front first, and the results still to come, oldest first.
  logic [IW-1:0] handles[$];
  list_result_t  awaited_q[$];
  int            mismatches = 0;

  // Builds one result; the count field is the list size after the request.
  function automatic list_result_t mk_result(logic [IW-1:0] v, status_t st,
                                             logic hit, logic fin);
    list_result_t r;
    r.item_out = v;
    r.status   = st;
    r.found    = hit;
    r.count    = COUNT_W'(handles.size());
    r.last     = fin;
    return r;
  endfunction

  // Applies one request to the list copy and queues the results it causes.
  task automatic apply_list_op(op_t op, logic [POS_W-1:0] pos, logic [IW-1:0] h);
    int            n;
    int            slot;
    status_t       st;
    logic          hit;
    logic [IW-1:0] taken;
    n     = handles.size();
    st    = ST_OK;
    hit   = 1'b0;
    taken = '0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        slot = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? n : int'(pos);
        // A full list is reported ahead of a bad position.
        if (n >= DEPTH_DEF) st = ST_FULL;
        else if (slot > n) st = ST_RANGE;
        else handles.insert(slot, h);
        awaited_q.push_back(mk_result('0, st, 1'b0, 1'b1));
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
        if (op == OP_REM_FRONT) slot = 0;
        else if (op == OP_REM_BACK) slot = (n == 0) ? 0 : n - 1;
        else slot = int'(pos);
        // An empty list is reported ahead of a bad position.
        if (n == 0) st = ST_EMPTY;
        else if (slot >= n) st = ST_RANGE;
        else begin
          taken = handles[slot];
          handles.delete(slot);
        end
        awaited_q.push_back(mk_result(taken, st, 1'b0, 1'b1));
      end
      OP_SEARCH: begin
        foreach (handles[i]) if (handles[i] == h) hit = 1'b1;
        awaited_q.push_back(mk_result('0, ST_OK, hit, 1'b1));
      end
      OP_DUMP: begin
        // An empty list still gives one closing result.
        if (n == 0) awaited_q.push_back(mk_result('0, ST_OK, 1'b0, 1'b1));
        for (int i = 0; i < n; i++)
          awaited_q.push_back(mk_result(handles[i], ST_OK, 1'b0, i == n - 1));
      end
      default: ;
    endcase
  endtask

  // Compares the result on the channel with the oldest awaited one.
  task automatic compare_result();
    list_result_t want;
    if (awaited_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no request waiting: item_out=%h status=%0d",
                 $time, out_mon.item_out, out_mon.status);
      return;
    end
    want = awaited_q.pop_front();
    if (out_mon.item_out !== want.item_out || out_mon.status !== want.status ||
        out_mon.found !== want.found || out_mon.count !== want.count ||
        out_mon.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: result mismatch: expected item_out=%h status=%0d found=%b",
                  " count=%0d last=%b, got item_out=%h status=%0d found=%b",
                  " count=%0d last=%b"},
                 $time, want.item_out, want.status, want.found, want.count,
                 want.last, out_mon.item_out, out_mon.status, out_mon.found,
                 out_mon.count, out_mon.last);
    end
  endtask

  // Results are checked before the request of the same edge is applied.
  always @(posedge clk) begin
    if (!rst_n) begin
      handles.delete();
      awaited_q.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) compare_result();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        apply_list_op(in_mon.op, in_mon.position, in_mon.item);
    end
    fail_count <= mismatches;
    pending    <= awaited_q.size();
    list_size  <= handles.size();
  end

endmodule

FILE: dv/tb_array_list_shift_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_list_shift_engine_top
// Drives list requests into the array list shift engine: a directed run over
// the empty, full and out-of-range cases, then random requests that fill the
// list to capacity, drain it and wander in between, under several patterns
// of sender idling and receiver stalling. The checker beside the block does
// the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_array_list_shift_engine_top;
  import alse_pkg::*;

  localparam int IW             = ITEM_WIDTH_DEF;
  localparam int PHASES         = 4;
  localparam int ITEMS_PER_MIX  = 85;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int POOL_DEPTH     = 32;

  // Request mixes: biased toward growing, shrinking, or neither.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_t;

  logic          clk;
  logic          rst_n;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            idle_tab[PHASES]  = '{0, 84, 0, 16};
  int            stall_tab[PHASES] = '{0, 0, 84, 16};
  int            list_fails;
  int            list_pending;
  int            list_size;
  logic [IW-1:0] handle_pool[$];

  alse_in_if  in_ch ();
  alse_out_if out_ch ();

  array_list_shift_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alse_result_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (list_fails),
    .pending    (list_pending),
    .list_size  (list_size)
  );

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #50_000_000;
    $display("array_list_shift_engine_top verification failed");
    $finish;
  end

  // Result side: ready is redrawn at every falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Presents one request from a falling edge and holds it until accepted.
  // Returns at a falling edge at which nothing has been driven yet.
  task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [IW-1:0] h);
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.position <= pos;
    in_ch.item     <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT) begin
      handle_pool.push_back(h);
      if (handle_pool.size() > POOL_DEPTH) void'(handle_pool.pop_front());
    end
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Holds off new requests until every awaited result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (list_pending != 0);
  endtask

  // One random request drawn from the given mix.
  task automatic send_random(mix_t mix);
    int               r;
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [IW-1:0]    h;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:
        op = (r < 80) ? op_t'($urandom_range(OP_INS_FRONT, OP_INS_AT)) :
             (r < 86) ? op_t'($urandom_range(OP_REM_FRONT, OP_REM_AT)) :
             (r < 93) ? OP_SEARCH : OP_DUMP;
      MIX_DRAIN:
        op = (r < 80) ? op_t'($urandom_range(OP_REM_FRONT, OP_REM_AT)) :
             (r < 86) ? op_t'($urandom_range(OP_INS_FRONT, OP_INS_AT)) :
             (r < 93) ? OP_SEARCH : OP_DUMP;
      default:
        op = op_t'($urandom_range(OP_INS_FRONT, OP_DUMP));
    endcase
    // Positions are mostly in range; the rest cover the whole field.
    pos = POS_W'($urandom_range(0, POS_MAX));
    if ($urandom_range(99) < 85) begin
      if (op == OP_INS_AT) pos = POS_W'($urandom_range(0, list_size));
      else if (op == OP_REM_AT && list_size > 0)
        pos = POS_W'($urandom_range(0, list_size - 1));
    end
    // Searches mostly look for a handle that was recently inserted.
    h = IW'($urandom());
    if (op == OP_SEARCH && handle_pool.size() > 0 && $urandom_range(99) < 60)
      h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
    send_request(op, pos, h);
  endtask

  // Stimulus.
  initial begin
    int   sent;
    int   seg;
    mix_t mix;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_INS_FRONT;
    in_ch.position = '0;
    in_ch.item     = '0;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, field extremes, every operation, range errors.
    send_request(OP_DUMP,      7'd0,   16'h0000);
    send_request(OP_REM_FRONT, 7'd0,   16'h0000);
    send_request(OP_REM_BACK,  7'd0,   16'h0000);
    send_request(OP_REM_AT,    7'd127, 16'h0000);
    send_request(OP_SEARCH,    7'd0,   16'h0000);
    send_request(OP_INS_AT,    7'd1,   16'h1111);
    send_request(OP_INS_AT,    7'd0,   16'h0000);
    send_request(OP_INS_BACK,  7'd0,   16'hFFFF);
    send_request(OP_INS_FRONT, 7'd0,   16'h8001);
    send_request(OP_INS_AT,    7'd3,   16'h7FFE);
    send_request(OP_INS_AT,    7'd127, 16'h2222);
    send_request(OP_INS_AT,    7'd2,   16'h5AA5);
    send_request(OP_SEARCH,    7'd64,  16'hFFFF);
    send_request(OP_SEARCH,    7'd0,   16'h1234);
    send_request(OP_DUMP,      7'd0,   16'h0000);
    send_request(OP_REM_AT,    7'd5,   16'h0000);
    send_request(OP_REM_AT,    7'd2,   16'h0000);
    send_request(OP_REM_FRONT, 7'd0,   16'h0000);
    send_request(OP_REM_BACK,  7'd0,   16'h0000);
    send_request(OP_REM_AT,    7'd0,   16'h0000);
    send_request(OP_REM_BACK,  7'd0,   16'h0000);
    send_request(OP_DUMP,      7'd0,   16'h0000);
    send_request(OP_INS_BACK,  7'd0,   16'hA5A5);
    send_request(OP_REM_AT,    7'd0,   16'h0000);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) begin
        // Fill to capacity, hit every full-list case, then drain to empty.
        while (list_size < DEPTH_DEF) send_random(MIX_FILL);
        send_request(OP_INS_FRONT, 7'd0,   IW'($urandom()));
        send_request(OP_INS_BACK,  7'd0,   IW'($urandom()));
        send_request(OP_INS_AT,    7'd64,  IW'($urandom()));
        send_request(OP_INS_AT,    7'd127, IW'($urandom()));
        send_random(MIX_ANY);
        send_request(OP_DUMP,      7'd0,   16'h0000);
        send_request(OP_REM_AT,    7'd64,  16'h0000);
        while (list_size > 0) send_random(MIX_DRAIN);
        send_request(OP_REM_FRONT, 7'd0,   16'h0000);
        send_request(OP_REM_AT,    7'd0,   16'h0000);
      end else begin
        // Random segments, each with its own bias.
        sent = 0;
        while (sent < ITEMS_PER_MIX) begin
          mix = mix_t'($urandom_range(MIX_FILL, MIX_ANY));
          seg = $urandom_range(5, 25);
          repeat (seg) send_random(mix);
          sent += seg;
        end
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (10) @(negedge clk);
    if (list_fails == 0 && list_pending == 0)
      $display("array_list_shift_engine_top verification clean");
    else
      $display("array_list_shift_engine_top verification failed");
    $finish;
  end

endmodule
